// ----- rtl/core/nlp_pkg.sv -----
package nlp_pkg;

    localparam int VAL_W          = 8;
    localparam int POS_W          = 3;
    localparam int LEN_W          = 4;
    // Positions are 3 bits wide, so no more than eight elements are ever addressed.
    localparam int POS_REACH      = 8;
    localparam int MAX_LENGTH_DEF = 8;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIV_RD,
        ST_PIV_CMP,
        ST_SUC_RD,
        ST_SUC_CMP,
        ST_SWAP_WR,
        ST_REV_RD,
        ST_REV_WR_LO,
        ST_REV_WR_HI,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_ADV,
        OP_PIV_READ,
        OP_PIV_NEXT,
        OP_PIV_FOUND,
        OP_NO_ASCENT,
        OP_SUC_READ,
        OP_SUC_NEXT,
        OP_SUC_SWAP,
        OP_SWAP_WR,
        OP_REV_READ,
        OP_REV_WR_LO,
        OP_REV_WR_HI,
        OP_EMIT_READ,
        OP_EMIT_LOAD
    } t_dp_op;

    typedef struct packed {
        logic len_zero;
        logic len_one;
        logic ascent;     // left < right of the pair just read
        logic succ_hit;   // pivot < element just read
        logic p_is_one;
        logic rev_more;   // lo < hi
        logic emit_last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/core/nlp_ram.sv -----
module nlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/core/nlp_ctrl.sv -----
module nlp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_cmd,
    input  nlp_pkg::t_dp_status i_status,
    output nlp_pkg::t_dp_op    o_op,
    output logic               o_stall
);

    import nlp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && i_cmd == CMD_ADVANCE) begin
                    if (i_status.len_one) begin
                        n_state = ST_EMIT_RD;
                    end else if (!i_status.len_zero) begin
                        n_state = ST_PIV_RD;
                    end
                end
            end
            ST_PIV_RD:  n_state = ST_PIV_CMP;
            ST_PIV_CMP: begin
                if (i_status.ascent) begin
                    n_state = ST_SUC_RD;
                end else if (i_status.p_is_one) begin
                    n_state = ST_REV_RD;
                end else begin
                    n_state = ST_PIV_RD;
                end
            end
            ST_SUC_RD:  n_state = ST_SUC_CMP;
            ST_SUC_CMP: n_state = i_status.succ_hit ? ST_SWAP_WR : ST_SUC_RD;
            ST_SWAP_WR: n_state = ST_REV_RD;
            ST_REV_RD:  n_state = i_status.rev_more ? ST_REV_WR_LO : ST_EMIT_RD;
            ST_REV_WR_LO: n_state = ST_REV_WR_HI;
            ST_REV_WR_HI: n_state = ST_REV_RD;
            ST_EMIT_RD: n_state = ST_EMIT_LD;
            ST_EMIT_LD: begin
                if (i_status.out_free) begin
                    n_state = i_status.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_op    = OP_NONE;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_op = (i_cmd == CMD_LOAD) ? OP_LOAD : OP_INIT_ADV;
                end
            end
            ST_PIV_RD:  o_op = OP_PIV_READ;
            ST_PIV_CMP: begin
                if (i_status.ascent) begin
                    o_op = OP_PIV_FOUND;
                end else if (i_status.p_is_one) begin
                    o_op = OP_NO_ASCENT;
                end else begin
                    o_op = OP_PIV_NEXT;
                end
            end
            ST_SUC_RD:  o_op = OP_SUC_READ;
            ST_SUC_CMP: o_op = i_status.succ_hit ? OP_SUC_SWAP : OP_SUC_NEXT;
            ST_SWAP_WR: o_op = OP_SWAP_WR;
            ST_REV_RD:  o_op = i_status.rev_more ? OP_REV_READ : OP_NONE;
            ST_REV_WR_LO: o_op = OP_REV_WR_LO;
            ST_REV_WR_HI: o_op = OP_REV_WR_HI;
            ST_EMIT_RD: o_op = OP_EMIT_READ;
            ST_EMIT_LD: o_op = i_status.out_free ? OP_EMIT_LOAD : OP_NONE;
            default:    o_op = OP_NONE;
        endcase
    end

endmodule

// ----- rtl/core/nlp_datapath.sv -----
module nlp_datapath #(
    parameter int DEPTH = nlp_pkg::MAX_LENGTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [nlp_pkg::LEN_W-1:0] i_cfg_wdata,
    input  logic [nlp_pkg::POS_W-1:0] i_position,
    input  logic [nlp_pkg::VAL_W-1:0] i_element_value,
    input  nlp_pkg::t_dp_op           i_op,
    output nlp_pkg::t_dp_status       o_status,
    input  logic                      i_stall,
    output logic                      o_valid,
    output logic [nlp_pkg::POS_W-1:0] o_out_position,
    output logic [nlp_pkg::VAL_W-1:0] o_out_value,
    output logic                      o_wrapped,
    output logic                      o_last_of_run
);

    import nlp_pkg::*;

    localparam int IW = $clog2(DEPTH);

    logic [LEN_W-1:0] r_active_length;
    logic [DEPTH-1:0] r_vld;
    logic             r_rvld_a;
    logic             r_rvld_b;
    logic [IW-1:0]    r_p;
    logic [IW-1:0]    r_k;
    logic [IW-1:0]    r_lo;
    logic [IW-1:0]    r_hi;
    logic [IW-1:0]    r_i;
    logic [VAL_W-1:0] r_pv;
    logic             r_wrapped;
    logic             r_out_valid;
    logic [IW-1:0]    r_out_pos;
    logic [VAL_W-1:0] r_out_val;
    logic             r_out_wrap;
    logic             r_out_last;

    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] len_m1;
    logic [IW-1:0]    last_idx;
    logic [IW-1:0]    p_m1;
    logic             load_ok;
    logic             we;
    logic [IW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic             re_a;
    logic             re_b;
    logic [IW-1:0]    raddr_a;
    logic [IW-1:0]    raddr_b;
    logic [VAL_W-1:0] ram_a;
    logic [VAL_W-1:0] ram_b;
    logic [VAL_W-1:0] rd_a;
    logic [VAL_W-1:0] rd_b;

    assign eff_len  = (r_active_length > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : r_active_length;
    assign len_m1   = eff_len - LEN_W'(1);
    assign last_idx = len_m1[IW-1:0];
    assign p_m1     = r_p - IW'(1);
    assign load_ok  = int'(i_position) < DEPTH;

    // never-written entries read as zero
    assign rd_a = r_rvld_a ? ram_a : '0;
    assign rd_b = r_rvld_b ? ram_b : '0;

    // store port selection
    always_comb begin
        we      = 1'b0;
        waddr   = r_lo;
        wdata   = rd_b;
        re_a    = 1'b0;
        re_b    = 1'b0;
        raddr_a = r_lo;
        raddr_b = r_hi;
        unique case (i_op)
            OP_LOAD: begin
                we    = load_ok;
                waddr = i_position[IW-1:0];
                wdata = i_element_value;
            end
            OP_PIV_READ: begin
                re_a    = 1'b1;
                re_b    = 1'b1;
                raddr_a = p_m1;
                raddr_b = r_p;
            end
            OP_SUC_READ: begin
                re_b    = 1'b1;
                raddr_b = r_k;
            end
            OP_SUC_SWAP: begin
                we    = 1'b1;
                waddr = r_k;
                wdata = r_pv;
            end
            OP_SWAP_WR: begin
                we    = 1'b1;
                waddr = p_m1;
                wdata = rd_b;
            end
            OP_REV_READ: begin
                re_a = 1'b1;
                re_b = 1'b1;
            end
            OP_REV_WR_LO: begin
                we    = 1'b1;
                waddr = r_lo;
                wdata = rd_b;
            end
            OP_REV_WR_HI: begin
                we    = 1'b1;
                waddr = r_hi;
                wdata = rd_a;
            end
            OP_EMIT_READ: begin
                re_a    = 1'b1;
                raddr_a = r_i;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    nlp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re_a    (re_a),
        .i_raddr_a (raddr_a),
        .o_rdata_a (ram_a),
        .i_re_b    (re_b),
        .i_raddr_b (raddr_b),
        .o_rdata_b (ram_b)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_length <= LEN_RESET;
            r_vld           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active_length <= i_cfg_wdata;
            end
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
            if (i_op == OP_EMIT_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers and output payload
    always_ff @(posedge i_clk) begin
        if (re_a) begin
            r_rvld_a <= r_vld[raddr_a];
        end
        if (re_b) begin
            r_rvld_b <= r_vld[raddr_b];
        end
        unique case (i_op)
            OP_INIT_ADV: begin
                r_p       <= last_idx;
                r_i       <= '0;
                r_wrapped <= 1'b0;
            end
            OP_PIV_NEXT: r_p <= p_m1;
            OP_PIV_FOUND: begin
                r_pv <= rd_a;
                r_k  <= last_idx;
            end
            OP_NO_ASCENT: begin
                r_wrapped <= 1'b1;
                r_lo      <= '0;
                r_hi      <= last_idx;
            end
            OP_SUC_NEXT: r_k <= r_k - IW'(1);
            OP_SWAP_WR: begin
                r_lo <= r_p;
                r_hi <= last_idx;
            end
            OP_REV_WR_HI: begin
                r_lo <= r_lo + IW'(1);
                r_hi <= r_hi - IW'(1);
            end
            OP_EMIT_LOAD: begin
                r_out_pos  <= r_i;
                r_out_val  <= rd_a;
                r_out_wrap <= r_wrapped;
                r_out_last <= (r_i == last_idx);
                r_i        <= r_i + IW'(1);
            end
            default: begin
                r_p <= r_p;
            end
        endcase
    end

    always_comb begin
        o_status.len_zero  = (eff_len == '0);
        o_status.len_one   = (eff_len == LEN_W'(1));
        o_status.ascent    = (rd_a < rd_b);
        o_status.succ_hit  = (r_pv < rd_b);
        o_status.p_is_one  = (r_p == IW'(1));
        o_status.rev_more  = (r_lo < r_hi);
        o_status.emit_last = (r_i == last_idx);
        o_status.out_free  = !r_out_valid || !i_stall;
    end

    assign o_valid        = r_out_valid;
    assign o_out_position = POS_W'(r_out_pos);
    assign o_out_value    = r_out_val;
    assign o_wrapped      = r_out_wrap;
    assign o_last_of_run  = r_out_last;

endmodule

// ----- rtl/core/next_lexicographic_permutation.sv -----
// Sequence: a load is written while idle. An advance over two or more elements walks the
//   pivot scan, then on an ascent the successor scan and swap, then the suffix reversal and
//   the emit of each element; each store read is followed by a compare or write state.
// Throughput: one item at a time; the input stalls until the last result of the run is
//   registered, longer while the receiver holds a result.
// Reset (synchronous, active low): store reads as zero, active_length = 8, no output.
module next_lexicographic_permutation #(
    parameter int MAX_LENGTH = nlp_pkg::MAX_LENGTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration: active_length
    input  logic                      i_cfg_we,
    input  logic [nlp_pkg::LEN_W-1:0] i_cfg_wdata,
    // input channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_cmd,
    input  logic [nlp_pkg::POS_W-1:0] i_position,
    input  logic [nlp_pkg::VAL_W-1:0] i_element_value,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [nlp_pkg::POS_W-1:0] o_out_position,
    output logic [nlp_pkg::VAL_W-1:0] o_out_value,
    output logic                      o_wrapped,
    output logic                      o_last_of_run
);

    import nlp_pkg::*;

    // Only positions 0..7 can be addressed, so the store never needs more than
    // eight entries whatever MAX_LENGTH is.
    localparam int DEPTH = (MAX_LENGTH < POS_REACH) ? MAX_LENGTH : POS_REACH;

    t_dp_op     dp_op;
    t_dp_status dp_status;

    // Controller: walks pivot scan, successor scan, swap, suffix reversal and
    // the per-element emit, one store access per step.
    nlp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .i_status (dp_status),
        .o_op     (dp_op),
        .o_stall  (o_stall)
    );

    // Datapath: element store (two registered read ports, one write port),
    // scan counters, comparators and the result register. The result register
    // lets the controller return to idle while the last transfer of a run waits.
    nlp_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_position      (i_position),
        .i_element_value (i_element_value),
        .i_op            (dp_op),
        .o_status        (dp_status),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_position  (o_out_position),
        .o_out_value     (o_out_value),
        .o_wrapped       (o_wrapped),
        .o_last_of_run   (o_last_of_run)
    );

    // A load transfer finishes in its own cycle.
    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_cmd == CMD_LOAD) |=> !o_stall)
        else $error("load transfer left the block busy");

    // An advance over two or more elements must start the scan.
    a_advance_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_cmd == CMD_ADVANCE
         && !dp_status.len_zero && !dp_status.len_one) |=> o_stall)
        else $error("advance transfer did not start the permutation step");

    // A new result that is not the last of its run means more emit work remains.
    a_emit_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid) && !o_last_of_run) |-> o_stall)
        else $error("run ended before its last result");

endmodule

// ----- dv/next_lexicographic_permutation_test.sv -----
module next_lexicographic_permutation_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nlp_pkg::*;

    // Run shape
    localparam int SETTLE_CYCLES  = 80;    // above the worst advance, covers no-result items
    localparam int LONG_HOLD      = 250;   // receiver hold-off that backs the block up
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer before giving up
    localparam int RANDOM_ITEMS   = 130;

    // One emitted element, in the order of the result ports
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
        logic             wrapped;
        logic             last;
    } t_perm_elem;

    // Tracks the element store and the length register, predicts each run of
    // emitted elements and checks them in order.
    class perm_scoreboard;
        logic [VAL_W-1:0] seq [MAX_LENGTH_DEF];
        logic [LEN_W-1:0] len_reg;
        t_perm_elem       elems_due [$];
        int errors, items_seen, advances_seen, wraps_seen, results_seen;

        function new();
            foreach (seq[i]) seq[i] = '0;
            len_reg = LEN_RESET;
        endfunction

        function void write_length(logic [LEN_W-1:0] v);
            len_reg = v;
        endfunction

        function int pending();
            return elems_due.size();
        endfunction

        function void reverse_span(int lo, int hi_excl);
            logic [VAL_W-1:0] t;
            int hi;
            hi = hi_excl - 1;
            while (lo < hi) begin
                t = seq[lo];
                seq[lo] = seq[hi];
                seq[hi] = t;
                lo++;
                hi--;
            end
        endfunction

        // Next permutation over seq[0..n-1]; returns 1 when it wrapped to ascending.
        function bit permute(int n);
            int p, k;
            logic [VAL_W-1:0] t;
            if (n < 2) return 1'b0;
            p = n - 1;
            while (p > 0 && !(seq[p-1] < seq[p])) p--;
            if (p == 0) begin
                reverse_span(0, n);
                return 1'b1;
            end
            k = n - 1;
            while (!(seq[p-1] < seq[k])) k--;
            t = seq[p-1];
            seq[p-1] = seq[k];
            seq[k] = t;
            reverse_span(p, n);
            return 1'b0;
        endfunction

        function void note_item(logic cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
            int n;
            bit wrap;
            t_perm_elem e;
            items_seen++;
            if (cmd == CMD_LOAD) begin
                if (pos < MAX_LENGTH_DEF) seq[pos] = val;
                return;
            end
            advances_seen++;
            n = int'(len_reg);
            if (n > MAX_LENGTH_DEF) n = MAX_LENGTH_DEF;
            if (n > POS_REACH) n = POS_REACH;
            wrap = permute(n);
            if (wrap) wraps_seen++;
            for (int i = 0; i < n; i++) begin
                e.pos     = POS_W'(i);
                e.value   = seq[i];
                e.wrapped = wrap;
                e.last    = (i == n - 1);
                elems_due.push_back(e);
            end
        endfunction

        function void check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_perm_elem got);
            t_perm_elem want;
            results_seen++;
            if (elems_due.size() == 0) begin
                $display("%0t: unexpected result pos=%0h value=%0h wrapped=%0h last=%0h",
                         $time, got.pos, got.value, got.wrapped, got.last);
                errors++;
                return;
            end
            want = elems_due.pop_front();
            check_field("out_position", VAL_W'(want.pos), VAL_W'(got.pos));
            check_field("out_value", want.value, got.value);
            check_field("wrapped", VAL_W'(want.wrapped), VAL_W'(got.wrapped));
            check_field("last_of_run", VAL_W'(want.last), VAL_W'(got.last));
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [LEN_W-1:0] i_cfg_wdata;
    logic             i_valid;
    logic             o_stall;
    logic             i_cmd;
    logic [POS_W-1:0] i_position;
    logic [VAL_W-1:0] i_element_value;
    logic             o_valid;
    logic             i_stall;
    logic [POS_W-1:0] o_out_position;
    logic [VAL_W-1:0] o_out_value;
    logic             o_wrapped;
    logic             o_last_of_run;

    perm_scoreboard sb = new();

    bit no_gaps;        // sender runs back to back when set
    bit long_hold_req;  // sender asks the receiver for one long hold-off
    int n_settings;     // register writes issued

    next_lexicographic_permutation DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_position      (i_position),
        .i_element_value (i_element_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_position  (o_out_position),
        .o_out_value     (o_out_value),
        .o_wrapped       (o_wrapped),
        .o_last_of_run   (o_last_of_run)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sender gap: mostly back to back or a few cycles, now and then a long pause.
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one item and returns at the falling edge after its transfer.
    // Valid stays high on return, so the next call can keep it up without a glitch.
    task automatic send_item(logic cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_cmd           <= cmd;
        i_position      <= pos;
        i_element_value <= val;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        sb.note_item(cmd, pos, val);
        @(negedge i_clk);
    endtask

    // Drains every pending result, lets the block settle (a trailing load or
    // zero-length advance leaves nothing to wait on), then writes active_length.
    task automatic set_length(logic [LEN_W-1:0] len);
        i_valid <= 1'b0;
        while (sb.pending() > 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_length(len);
        n_settings++;
    endtask

    // Receiver: random stall runs, mostly short with a few long ones, quiet
    // stretches with no stalls, and one long hold-off when the sender asks.
    initial begin : receiver
        int run_left, mode_left;
        bit quiet;
        run_left  = 0;
        mode_left = 0;
        quiet     = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                run_left      = LONG_HOLD;
            end
            if (mode_left == 0) begin
                quiet     = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 200);
            end else begin
                mode_left--;
            end
            if (run_left > 0) begin
                i_stall <= 1'b1;
                run_left--;
            end else if (!quiet && $urandom_range(0, 99) < 20) begin
                i_stall <= 1'b1;
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                       : $urandom_range(0, 2);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Result monitor: a transfer happens at a rising edge with valid up and no stall.
    initial begin : result_monitor
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
                sb.check_result('{o_out_position, o_out_value, o_wrapped, o_last_of_run});
        end
    end

    // Watchdog: consecutive cycles with no transfer on either channel.
    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results still pending",
                         $time, idle, sb.pending());
                $display("next_lexicographic_permutation test failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int len_plan [15] = '{8, 3, 4, 9, 5, 0, 6, 7, 2, 1, 8, 15, 5, 3, 8};
        logic [VAL_W-1:0] desc_vals [8] = '{8'hFF, 8'hC8, 8'h80, 8'h40, 8'h20, 8'h05, 8'h01, 8'h00};
        int phase, n_fill, n_more, start_items;
        bit narrow;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_valid         = 1'b0;
        i_cmd           = CMD_LOAD;
        i_position      = '0;
        i_element_value = '0;
        no_gaps         = 1'b0;
        long_hold_req   = 1'b0;
        n_settings      = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- Directed part ---
        // Reset length of 8 over an all-zero store: no ascent, so it wraps.
        send_item(CMD_ADVANCE, '0, '0);
        // Strictly descending fill, extremes of position and value: the last
        // permutation, which wraps to ascending; then one ordinary step.
        for (int i = 0; i < 8; i++) send_item(CMD_LOAD, POS_W'(i), desc_vals[i]);
        send_item(CMD_ADVANCE, '0, '0);
        send_item(CMD_ADVANCE, '0, '0);

        // Length zero: advances change nothing and emit nothing.
        set_length(4'd0);
        send_item(CMD_ADVANCE, '0, '0);
        send_item(CMD_LOAD, 3'd3, 8'hAA);
        send_item(CMD_ADVANCE, '0, '0);

        // Length one: one element out, never wrapped.
        set_length(4'd1);
        send_item(CMD_ADVANCE, '0, '0);

        // Length above the store: saturates to eight.
        set_length(4'd15);
        send_item(CMD_ADVANCE, '0, '0);

        // Length two with equal values (no ascent), then a real swap and a wrap.
        set_length(4'd2);
        send_item(CMD_LOAD, 3'd0, 8'd5);
        send_item(CMD_LOAD, 3'd1, 8'd5);
        send_item(CMD_ADVANCE, '0, '0);
        send_item(CMD_LOAD, 3'd1, 8'd9);
        send_item(CMD_ADVANCE, '0, '0);
        send_item(CMD_ADVANCE, '0, '0);

        // --- Random part ---
        // Each phase: new length, a fill of the active part, then mostly
        // advances walking through permutations with stray loads mixed in.
        start_items = sb.items_seen;
        phase = 0;
        while (sb.items_seen - start_items < RANDOM_ITEMS) begin
            set_length(LEN_W'(len_plan[phase % 15]));
            narrow = 1'($urandom_range(0, 1));  // tiny value range gives repeats
            n_fill = (len_plan[phase % 15] > 8) ? 8 : len_plan[phase % 15];
            if (n_fill == 0) n_fill = 1;
            if (phase == 0) begin
                // Back-pressure phase: receiver holds off while advances keep coming.
                no_gaps = 1'b1;
                for (int i = 0; i < 8; i++)
                    send_item(CMD_LOAD, POS_W'(i), VAL_W'($urandom_range(0, 255)));
                long_hold_req = 1'b1;
                repeat (8) send_item(CMD_ADVANCE, '0, '0);
            end else begin
                no_gaps = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < n_fill; i++)
                    send_item(CMD_LOAD, POS_W'(i),
                              narrow ? VAL_W'($urandom_range(0, 3))
                                     : VAL_W'($urandom_range(0, 255)));
                n_more = $urandom_range(6, 14);
                repeat (n_more) begin
                    if ($urandom_range(0, 99) < 80)
                        send_item(CMD_ADVANCE, POS_W'($urandom_range(0, 7)),
                                  VAL_W'($urandom_range(0, 255)));
                    else
                        send_item(CMD_LOAD, POS_W'($urandom_range(0, 7)),
                                  VAL_W'($urandom_range(0, 255)));
                end
            end
            phase++;
        end

        // --- Wind-down ---
        i_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run moved %0d items in (%0d advances, %0d wrapping) and %0d elements out,",
                 sb.items_seen, sb.advances_seen, sb.wraps_seen, sb.results_seen);
        $display("across %0d length settings including 0, 1, 2, 8 and saturated 9 and 15.",
                 n_settings);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("next_lexicographic_permutation test passed");
        end else begin
            $display("next_lexicographic_permutation test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/nlp_pkg.sv
rtl/core/nlp_ram.sv
rtl/core/nlp_ctrl.sv
rtl/core/nlp_datapath.sv
rtl/core/next_lexicographic_permutation.sv
dv/next_lexicographic_permutation_test.sv
